FILE: rtl/sip_pkg.sv
// Types and constants shared by the segment intersection pipeline.
// Used by the quotient pipeline and by the top level; depends on nothing.
`default_nettype none
package sip_pkg;

   localparam int CoordW = 16;
   localparam int DiffW  = CoordW + 1;
   localparam int ProdW  = 2 * DiffW;
   localparam int SplitW = 17;
   localparam int PartW  = 36;
   localparam int NumW   = 52;
   localparam int DenW   = 33;
   localparam int QuoW   = 24;
   localparam int FracSh = 8;
   localparam int RemW   = NumW + FracSh;
   localparam int DivLat = QuoW + 2;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [DiffW-1:0]  diff_type;
   typedef logic signed [ProdW-1:0]  prod_type;
   typedef logic signed [PartW-1:0]  part_type;
   typedef logic signed [NumW-1:0]   num_type;
   typedef logic        [DenW-1:0]   den_type;
   typedef logic signed [QuoW-1:0]   quo_type;

   typedef enum logic [1:0] {
      KIND_MISS = 2'd0,
      KIND_BOTH = 2'd1,
      KIND_VERT = 2'd2,
      KIND_GEN  = 2'd3
   } kind_type;

   typedef struct packed {
      logic vld;
      logic hit;
      logic pv;
   } flags_type;

endpackage
`default_nettype wire

FILE: rtl/sip_div.sv
// Pipelined signed divider: trunc(num * 256 / den), one quotient bit per stage.
// Depends on sip_pkg; the quotient is assumed to fit in QuoW bits.
`default_nettype none
module sip_div (
   input  wire                  clock,
   input  wire                  en,
   input  wire sip_pkg::num_type num_in,
   input  wire sip_pkg::den_type den_in,
   output sip_pkg::quo_type     quo_out
);
   import sip_pkg::*;

   logic [RemW-1:0] rem_ff [0:QuoW];
   den_type         den_ff [0:QuoW];
   logic [QuoW-1:0] q_ff   [0:QuoW];
   logic            neg_ff [0:QuoW];
   quo_type         quo_ff;
   logic [NumW-1:0] mag_in;

   assign mag_in = num_in[NumW-1] ? NumW'(-num_in) : NumW'(num_in);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {mag_in, {FracSh{1'b0}}};
         den_ff[0] <= den_in;
         q_ff[0]   <= '0;
         neg_ff[0] <= num_in[NumW-1];
      end
   end

   for (genvar k = 0; k < QuoW; k++) begin : g_stage
      logic [RemW-1:0] trial;
      logic            ge;
      assign trial = RemW'(den_ff[k]) << (QuoW - 1 - k);
      assign ge    = rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - trial : rem_ff[k];
            den_ff[k+1] <= den_ff[k];
            q_ff[k+1]   <= q_ff[k] | (QuoW'(ge) << (QuoW - 1 - k));
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[QuoW] ? quo_type'(-q_ff[QuoW]) : quo_type'(q_ff[QuoW]);
      end
   end

   assign quo_out = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/segment_intersection_point.sv
// Top level: intersection test and point of two Q8.8 segments, fully pipelined.
// Depends on sip_pkg and sip_div.
//
//   channel | port group | word layout (lowest bit first)
//   request | req_*      | ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (16 bits each)
//   result  | rsp_*      | hit, point_valid, cross_x (24), cross_y (24), zero pad
//
// One word enters every cycle unless the result is held; each word passes eight
// arithmetic stages and the 26 stages of the bit-per-stage quotient pipelines.
// Reset clears the valid bits and travelling flags only. When the result is held,
// the whole pipeline holds and req_tready falls; nothing is dropped or repeated.
`default_nettype none
module segment_intersection_point (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [127:0] req_tdata,  // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata   // hit, point_valid, cross_x, cross_y, pad
);
   import sip_pkg::*;

   logic adv;
   logic out_vld;
   assign adv        = !out_vld || rsp_tready;
   assign req_tready = adv;

   // Stage 1: order each segment by x.
   coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   logic      swa, swb;
   assign ax0 = $signed(req_tdata[15:0]);
   assign ay0 = $signed(req_tdata[31:16]);
   assign ax1 = $signed(req_tdata[47:32]);
   assign ay1 = $signed(req_tdata[63:48]);
   assign bx0 = $signed(req_tdata[79:64]);
   assign by0 = $signed(req_tdata[95:80]);
   assign bx1 = $signed(req_tdata[111:96]);
   assign by1 = $signed(req_tdata[127:112]);
   assign swa = ax1 < ax0;
   assign swb = bx1 < bx0;

   logic      s1_vld_ff;
   coord_type s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   coord_type s1_x3_ff, s1_y3_ff, s1_x4_ff, s1_y4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x1_ff <= swa ? ax1 : ax0;
         s1_y1_ff <= swa ? ay1 : ay0;
         s1_x2_ff <= swa ? ax0 : ax1;
         s1_y2_ff <= swa ? ay0 : ay1;
         s1_x3_ff <= swb ? bx1 : bx0;
         s1_y3_ff <= swb ? by1 : by0;
         s1_x4_ff <= swb ? bx0 : bx1;
         s1_y4_ff <= swb ? by0 : by1;
      end
   end

   // Stage 2: classify, differences, vertical-case operand selection.
   logic      v1, v2;
   coord_type ymaxa, ymina, ymaxb, yminb, lo, hi;
   coord_type vx, vy0, vy1, sx0, sy0, sx1, sy1;
   kind_type  s2_kind_in;

   assign v1    = s1_x1_ff == s1_x2_ff;
   assign v2    = s1_x3_ff == s1_x4_ff;
   assign ymaxa = (s1_y1_ff > s1_y2_ff) ? s1_y1_ff : s1_y2_ff;
   assign ymina = (s1_y1_ff > s1_y2_ff) ? s1_y2_ff : s1_y1_ff;
   assign ymaxb = (s1_y3_ff > s1_y4_ff) ? s1_y3_ff : s1_y4_ff;
   assign yminb = (s1_y3_ff > s1_y4_ff) ? s1_y4_ff : s1_y3_ff;
   assign lo    = (s1_x1_ff > s1_x3_ff) ? s1_x1_ff : s1_x3_ff;
   assign hi    = (s1_x2_ff < s1_x4_ff) ? s1_x2_ff : s1_x4_ff;
   assign vx    = v1 ? s1_x1_ff : s1_x3_ff;
   assign vy0   = v1 ? ymina : yminb;
   assign vy1   = v1 ? ymaxa : ymaxb;
   assign sx0   = v1 ? s1_x3_ff : s1_x1_ff;
   assign sy0   = v1 ? s1_y3_ff : s1_y1_ff;
   assign sx1   = v1 ? s1_x4_ff : s1_x2_ff;
   assign sy1   = v1 ? s1_y4_ff : s1_y2_ff;

   always_comb begin
      priority if (s1_x2_ff < s1_x3_ff) begin
         s2_kind_in = KIND_MISS;
      end else if (v1 && v2) begin
         s2_kind_in = KIND_BOTH;
      end else if (v1 || v2) begin
         s2_kind_in = KIND_VERT;
      end else begin
         s2_kind_in = KIND_GEN;
      end
   end

   logic      s2_vld_ff, s2_both_ff, s2_vin_ff;
   kind_type  s2_kind_ff;
   diff_type  s2_dx1_ff, s2_dy1_ff, s2_dx2_ff, s2_dy2_ff, s2_ex_ff, s2_ey_ff;
   diff_type  s2_a_ff, s2_b_ff, s2_vdx_ff, s2_vdy_ff, s2_vrel_ff;
   coord_type s2_x1_ff, s2_y1_ff, s2_vx_ff, s2_vlo_ff, s2_vhi_ff, s2_sy0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_kind_ff <= s2_kind_in;
         s2_both_ff <= (s1_x1_ff == s1_x3_ff) && !(ymaxa < yminb || ymina > ymaxb);
         s2_vin_ff  <= (sx0 <= vx) && (sx1 >= vx);
         s2_dx1_ff  <= DiffW'(s1_x2_ff) - DiffW'(s1_x1_ff);
         s2_dy1_ff  <= DiffW'(s1_y2_ff) - DiffW'(s1_y1_ff);
         s2_dx2_ff  <= DiffW'(s1_x4_ff) - DiffW'(s1_x3_ff);
         s2_dy2_ff  <= DiffW'(s1_y4_ff) - DiffW'(s1_y3_ff);
         s2_ex_ff   <= DiffW'(s1_x3_ff) - DiffW'(s1_x1_ff);
         s2_ey_ff   <= DiffW'(s1_y3_ff) - DiffW'(s1_y1_ff);
         s2_a_ff    <= DiffW'(s1_x1_ff) - DiffW'(lo);
         s2_b_ff    <= DiffW'(s1_x1_ff) - DiffW'(hi);
         s2_vdx_ff  <= DiffW'(sx1) - DiffW'(sx0);
         s2_vdy_ff  <= DiffW'(sy1) - DiffW'(sy0);
         s2_vrel_ff <= DiffW'(vx) - DiffW'(sx0);
         s2_x1_ff   <= s1_x1_ff;
         s2_y1_ff   <= s1_y1_ff;
         s2_vx_ff   <= vx;
         s2_vlo_ff  <= vy0;
         s2_vhi_ff  <= vy1;
         s2_sy0_ff  <= sy0;
      end
   end

   // Stage 3: cross products and vertical-case products.
   logic      s3_vld_ff, s3_both_ff, s3_vin_ff;
   kind_type  s3_kind_ff;
   prod_type  s3_p1_ff, s3_p2_ff, s3_p3_ff, s3_p4_ff;
   prod_type  s3_m1_ff, s3_m2_ff, s3_ml_ff, s3_mh_ff;
   diff_type  s3_dx1_ff, s3_dy1_ff, s3_a_ff, s3_b_ff, s3_vdx_ff;
   coord_type s3_x1_ff, s3_y1_ff, s3_vx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_p1_ff   <= ProdW'(s2_dx1_ff) * ProdW'(s2_dy2_ff);
         s3_p2_ff   <= ProdW'(s2_dy1_ff) * ProdW'(s2_dx2_ff);
         s3_p3_ff   <= ProdW'(s2_ex_ff) * ProdW'(s2_dy2_ff);
         s3_p4_ff   <= ProdW'(s2_ey_ff) * ProdW'(s2_dx2_ff);
         s3_m1_ff   <= ProdW'(s2_sy0_ff) * ProdW'(s2_vdx_ff);
         s3_m2_ff   <= ProdW'(s2_vdy_ff) * ProdW'(s2_vrel_ff);
         s3_ml_ff   <= ProdW'(s2_vlo_ff) * ProdW'(s2_vdx_ff);
         s3_mh_ff   <= ProdW'(s2_vhi_ff) * ProdW'(s2_vdx_ff);
         s3_kind_ff <= s2_kind_ff;
         s3_both_ff <= s2_both_ff;
         s3_vin_ff  <= s2_vin_ff;
         s3_dx1_ff  <= s2_dx1_ff;
         s3_dy1_ff  <= s2_dy1_ff;
         s3_a_ff    <= s2_a_ff;
         s3_b_ff    <= s2_b_ff;
         s3_vdx_ff  <= s2_vdx_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
         s3_vx_ff   <= s2_vx_ff;
      end
   end

   // Stage 4: denominator, line parameter numerator, vertical-case numerator.
   logic      s4_vld_ff, s4_both_ff, s4_vin_ff;
   kind_type  s4_kind_ff;
   prod_type  s4_den_ff, s4_tn_ff, s4_num_ff, s4_ml_ff, s4_mh_ff;
   diff_type  s4_dx1_ff, s4_dy1_ff, s4_a_ff, s4_b_ff, s4_vdx_ff;
   coord_type s4_x1_ff, s4_y1_ff, s4_vx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_den_ff  <= s3_p1_ff - s3_p2_ff;
         s4_tn_ff   <= s3_p3_ff - s3_p4_ff;
         s4_num_ff  <= s3_m1_ff + s3_m2_ff;
         s4_ml_ff   <= s3_ml_ff;
         s4_mh_ff   <= s3_mh_ff;
         s4_kind_ff <= s3_kind_ff;
         s4_both_ff <= s3_both_ff;
         s4_vin_ff  <= s3_vin_ff;
         s4_dx1_ff  <= s3_dx1_ff;
         s4_dy1_ff  <= s3_dy1_ff;
         s4_a_ff    <= s3_a_ff;
         s4_b_ff    <= s3_b_ff;
         s4_vdx_ff  <= s3_vdx_ff;
         s4_x1_ff   <= s3_x1_ff;
         s4_y1_ff   <= s3_y1_ff;
         s4_vx_ff   <= s3_vx_ff;
      end
   end

   // Stage 5: make the denominator positive; vertical-case range test.
   logic      s5_vld_ff, s5_both_ff, s5_vhit_ff, s5_denz_ff;
   kind_type  s5_kind_ff;
   prod_type  s5_den_ff, s5_tn_ff, s5_num_ff;
   diff_type  s5_dx1_ff, s5_dy1_ff, s5_a_ff, s5_b_ff, s5_vdx_ff;
   coord_type s5_x1_ff, s5_y1_ff, s5_vx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_den_ff  <= s4_den_ff[ProdW-1] ? -s4_den_ff : s4_den_ff;
         s5_tn_ff   <= s4_den_ff[ProdW-1] ? -s4_tn_ff : s4_tn_ff;
         s5_denz_ff <= s4_den_ff == '0;
         s5_vhit_ff <= s4_vin_ff && (s4_ml_ff <= s4_num_ff) && (s4_mh_ff >= s4_num_ff);
         s5_num_ff  <= s4_num_ff;
         s5_kind_ff <= s4_kind_ff;
         s5_both_ff <= s4_both_ff;
         s5_dx1_ff  <= s4_dx1_ff;
         s5_dy1_ff  <= s4_dy1_ff;
         s5_a_ff    <= s4_a_ff;
         s5_b_ff    <= s4_b_ff;
         s5_vdx_ff  <= s4_vdx_ff;
         s5_x1_ff   <= s4_x1_ff;
         s5_y1_ff   <= s4_y1_ff;
         s5_vx_ff   <= s4_vx_ff;
      end
   end

   // Stage 6: partial products against the split denominator and parameter.
   part_type dl, dh, tl, th;
   assign dl = PartW'($signed({1'b0, s5_den_ff[SplitW-1:0]}));
   assign dh = PartW'($signed({1'b0, s5_den_ff[DenW-1:SplitW]}));
   assign tl = PartW'($signed({1'b0, s5_tn_ff[SplitW-1:0]}));
   assign th = PartW'($signed(s5_tn_ff[ProdW-1:SplitW]));

   logic      s6_vld_ff, s6_both_ff, s6_vhit_ff, s6_denz_ff;
   kind_type  s6_kind_ff;
   part_type  s6_xl_ff, s6_xh_ff, s6_yl_ff, s6_yh_ff, s6_al_ff, s6_ah_ff;
   part_type  s6_bl_ff, s6_bh_ff, s6_ul_ff, s6_uh_ff, s6_wl_ff, s6_wh_ff;
   prod_type  s6_den_ff, s6_num_ff;
   diff_type  s6_vdx_ff;
   coord_type s6_vx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_xl_ff   <= PartW'(s5_x1_ff) * dl;
         s6_xh_ff   <= PartW'(s5_x1_ff) * dh;
         s6_yl_ff   <= PartW'(s5_y1_ff) * dl;
         s6_yh_ff   <= PartW'(s5_y1_ff) * dh;
         s6_al_ff   <= PartW'(s5_a_ff) * dl;
         s6_ah_ff   <= PartW'(s5_a_ff) * dh;
         s6_bl_ff   <= PartW'(s5_b_ff) * dl;
         s6_bh_ff   <= PartW'(s5_b_ff) * dh;
         s6_ul_ff   <= PartW'(s5_dx1_ff) * tl;
         s6_uh_ff   <= PartW'(s5_dx1_ff) * th;
         s6_wl_ff   <= PartW'(s5_dy1_ff) * tl;
         s6_wh_ff   <= PartW'(s5_dy1_ff) * th;
         s6_den_ff  <= s5_den_ff;
         s6_num_ff  <= s5_num_ff;
         s6_denz_ff <= s5_denz_ff;
         s6_vhit_ff <= s5_vhit_ff;
         s6_kind_ff <= s5_kind_ff;
         s6_both_ff <= s5_both_ff;
         s6_vdx_ff  <= s5_vdx_ff;
         s6_vx_ff   <= s5_vx_ff;
      end
   end

   // Stage 7: assemble point numerators and the range-test sums.
   num_type dx1tn;
   assign dx1tn = (NumW'(s6_uh_ff) <<< SplitW) + NumW'(s6_ul_ff);

   logic      s7_vld_ff, s7_both_ff, s7_vhit_ff, s7_denz_ff;
   kind_type  s7_kind_ff;
   num_type   s7_xn_ff, s7_yn_ff, s7_d1_ff, s7_d2_ff;
   prod_type  s7_den_ff, s7_num_ff;
   diff_type  s7_vdx_ff;
   coord_type s7_vx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_xn_ff   <= (NumW'(s6_xh_ff) <<< SplitW) + NumW'(s6_xl_ff) + dx1tn;
         s7_yn_ff   <= (NumW'(s6_yh_ff) <<< SplitW) + NumW'(s6_yl_ff)
                     + (NumW'(s6_wh_ff) <<< SplitW) + NumW'(s6_wl_ff);
         s7_d1_ff   <= (NumW'(s6_ah_ff) <<< SplitW) + NumW'(s6_al_ff) + dx1tn;
         s7_d2_ff   <= (NumW'(s6_bh_ff) <<< SplitW) + NumW'(s6_bl_ff) + dx1tn;
         s7_den_ff  <= s6_den_ff;
         s7_num_ff  <= s6_num_ff;
         s7_denz_ff <= s6_denz_ff;
         s7_vhit_ff <= s6_vhit_ff;
         s7_kind_ff <= s6_kind_ff;
         s7_both_ff <= s6_both_ff;
         s7_vdx_ff  <= s6_vdx_ff;
         s7_vx_ff   <= s6_vx_ff;
      end
   end

   // Stage 8: decide the case and choose the divider operands.
   logic    s8_hit_in, s8_pv_in;
   num_type s8_nx_in, s8_ny_in;
   den_type s8_dx_in, s8_dy_in;

   always_comb begin
      s8_nx_in = NumW'(s7_vx_ff);
      s8_ny_in = NumW'(s7_num_ff);
      s8_dx_in = DenW'(1);
      s8_dy_in = DenW'($unsigned(s7_vdx_ff));
      unique case (s7_kind_ff)
         KIND_MISS: begin
            s8_hit_in = 1'b0;
            s8_pv_in  = 1'b0;
         end
         KIND_BOTH: begin
            s8_hit_in = s7_both_ff;
            s8_pv_in  = 1'b0;
         end
         KIND_VERT: begin
            s8_hit_in = s7_vhit_ff;
            s8_pv_in  = s7_vhit_ff;
         end
         KIND_GEN: begin
            s8_hit_in = !s7_denz_ff && !s7_d1_ff[NumW-1]
                        && (s7_d2_ff[NumW-1] || (s7_d2_ff == '0));
            s8_pv_in  = s8_hit_in;
            s8_nx_in  = s7_xn_ff;
            s8_ny_in  = s7_yn_ff;
            s8_dx_in  = s7_den_ff[DenW-1:0];
            s8_dy_in  = s7_den_ff[DenW-1:0];
         end
         default: begin
            s8_hit_in = 1'b0;
            s8_pv_in  = 1'b0;
         end
      endcase
   end

   logic    s8_vld_ff, s8_hit_ff, s8_pv_ff;
   num_type s8_nx_ff, s8_ny_ff;
   den_type s8_dx_ff, s8_dy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_hit_ff <= s8_hit_in;
         s8_pv_ff  <= s8_pv_in;
         s8_nx_ff  <= s8_nx_in;
         s8_ny_ff  <= s8_ny_in;
         s8_dx_ff  <= s8_dx_in;
         s8_dy_ff  <= s8_dy_in;
      end
   end

   // Quotients and the flags that travel beside them.
   quo_type   qx, qy;
   flags_type fl_ff [0:DivLat-1];

   sip_div u_divx (
      .clock   (clock),
      .en      (adv),
      .num_in  (s8_nx_ff),
      .den_in  (s8_dx_ff),
      .quo_out (qx)
   );

   sip_div u_divy (
      .clock   (clock),
      .en      (adv),
      .num_in  (s8_ny_ff),
      .den_in  (s8_dy_ff),
      .quo_out (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
         for (int i = 0; i < DivLat; i++) begin
            fl_ff[i] <= '0;
         end
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
         fl_ff[0]  <= '{vld: s8_vld_ff, hit: s8_hit_ff, pv: s8_pv_ff};
         for (int i = 1; i < DivLat; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   assign out_vld    = fl_ff[DivLat-1].vld;
   assign rsp_tvalid = out_vld;
   assign rsp_tdata  = {6'b0,
                        fl_ff[DivLat-1].pv ? qy : quo_type'(0),
                        fl_ff[DivLat-1].pv ? qx : quo_type'(0),
                        fl_ff[DivLat-1].pv,
                        fl_ff[DivLat-1].hit};

endmodule
`default_nettype wire
